// ----- rtl/morph_angle_ramp_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - assertion macros
// Clocked implication helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MORPH_ANGLE_RAMP_SEQUENCER_MACROS_SVH
`define MORPH_ANGLE_RAMP_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MARS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define MARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/mars_pkg.sv -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - package
// Item types, phase codes, configuration indexes, fixed-point constants and a bucket helper.
// ----------------------------------------------------------------------------
package mars_pkg;

    // input item
    typedef struct packed {
        logic [31:0] now_ms;
        logic        restart;
        logic        queue_ready;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        send_valid;
        logic [6:0]  cmd_angle;
        logic [14:0] angle_q8;
        logic [1:0]  phase;
        logic        motors_idle;
        logic        exit_request;
    } t_out_item;

    // ramp stage result handed to the sequencer
    typedef struct packed {
        t_in_item    item;
        logic        sat;
        logic [13:0] ramp_q8;
    } t_calc;

    // phase codes as shown on the result item
    localparam logic [1:0] PHASE_RAMP  = 2'd0;
    localparam logic [1:0] PHASE_HOLD  = 2'd1;
    localparam logic [1:0] PHASE_DWELL = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS  = 2'd1;

    localparam logic [15:0] RATE_DEFAULT  = 16'd3840;
    localparam logic [15:0] DWELL_DEFAULT = 16'd2000;

    // angles, Q7.8
    localparam logic [14:0] ANGLE_45_Q8 = 15'd11520;
    localparam logic [14:0] ANGLE_90_Q8 = 15'd23040;
    localparam logic [14:0] ROUND_HALF  = 15'd128;

    // rate * elapsed at or above this saturates the ramp at 45 degrees
    localparam logic [47:0] SAT_PRODUCT = 48'd11520000;
    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^24
    localparam logic [24:0] RECIP_1000  = 25'd17179870;
    localparam int unsigned RECIP_SHIFT = 34;

    // timing, ms
    localparam logic [31:0] HOLD_MS       = 32'd1000;
    localparam logic [31:0] CHANGE_MS     = 32'd80;
    localparam logic [31:0] KEEPALIVE_MS  = 32'd300;
    localparam logic [31:0] REPEAT_MS     = 32'd40;
    localparam logic [31:0] DWELL_SEND_MS = 32'd120;

    // whole-degree commands and markers
    localparam logic [5:0] CMD_MAX     = 6'd45;
    localparam logic [6:0] CMD_90      = 7'd90;
    localparam logic [6:0] ANGLE_NONE  = 7'd127;
    localparam logic [3:0] BUCKET_NONE = 4'd15;
    localparam logic [1:0] REPEATS     = 2'd2;

    // cmd / 5 for cmd in 0..45, as a multiply by 13 and a shift by 6
    function automatic logic [3:0] bucket_of(input logic [5:0] cmd);
        logic [9:0] prod;
        prod = 10'(cmd) * 10'd13;
        return prod[9:6];
    endfunction

endpackage

// ----- rtl/mars_ramp_calc.sv -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - ramp angle pipeline
// Three stages: elapsed time, rate product, divide by 1000 with saturation.
// ----------------------------------------------------------------------------
module mars_ramp_calc
    import mars_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic [15:0] i_rate_q8,
    output logic     o_calc_valid,
    output t_calc    o_calc
);

    logic        r_v0, r_v1, r_v2;
    logic [31:0] r_ramp_start;
    t_in_item    r_item0, r_item1, r_item2;
    logic [31:0] r_elapsed;
    logic [47:0] r_prod;
    logic        r_sat;
    logic [13:0] r_quot;

    logic [31:0] n_elapsed;
    logic [47:0] n_prod;
    logic        n_sat;
    logic [48:0] n_recip;
    logic [13:0] n_quot;

    // a restart item starts its own ramp, so its elapsed time is zero
    assign n_elapsed = i_in_item.restart ? 32'd0 : (i_in_item.now_ms - r_ramp_start);

    // 32 x 16 product
    assign n_prod = 48'(r_elapsed) * 48'(i_rate_q8);

    // saturation test and reciprocal divide; below saturation the product fits 24 bits
    assign n_sat   = (r_prod >= SAT_PRODUCT);
    assign n_recip = 49'(r_prod[23:0]) * 49'(RECIP_1000);
    assign n_quot  = n_recip[RECIP_SHIFT +: 14];

    // control: stage valids and the ramp start time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_ramp_start <= 32'd0;
        end else if (i_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_in_valid && i_in_item.restart) begin
                r_ramp_start <= i_in_item.now_ms;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item0   <= i_in_item;
            r_elapsed <= n_elapsed;
            r_item1   <= r_item0;
            r_prod    <= n_prod;
            r_item2   <= r_item1;
            r_sat     <= n_sat;
            r_quot    <= n_quot;
        end
    end

    assign o_calc_valid   = r_v2;
    assign o_calc.item    = r_item2;
    assign o_calc.sat     = r_sat;
    assign o_calc.ramp_q8 = r_sat ? ANGLE_45_Q8[13:0] : r_quot;

endmodule

// ----- rtl/mars_seq.sv -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - phase sequencer
// Phase state, send timers and bucket repeats, plus the result register.
// ----------------------------------------------------------------------------
module mars_seq
    import mars_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_calc_valid,
    input  t_calc     i_calc,
    input  logic [15:0] i_dwell_ms,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_RAMP  = PHASE_RAMP,
        S_HOLD  = PHASE_HOLD,
        S_DWELL = PHASE_DWELL,
        S_DONE  = PHASE_DONE
    } t_state;

    // registered state
    t_state      r_phase;
    logic [31:0] r_hold_start, r_dwell_start, r_last_time;
    logic [6:0]  r_last_angle;
    logic [3:0]  r_bucket;
    logic [1:0]  r_rep;
    logic [5:0]  r_rep_angle;
    logic        r_out_valid;
    t_out_item   r_out;

    // state after an optional restart
    t_state      c_phase;
    logic [31:0] c_hold_start, c_dwell_start, c_last_time;
    logic [6:0]  c_last_angle;
    logic [3:0]  c_bucket;
    logic [1:0]  c_rep;
    logic [5:0]  c_rep_angle;

    // next state
    t_state      n_phase;
    logic [31:0] n_hold_start, n_dwell_start, n_last_time;
    logic [6:0]  n_last_angle;
    logic [3:0]  n_bucket;
    logic [1:0]  n_rep;
    logic [5:0]  n_rep_angle;
    t_out_item   n_out;

    // ramp/hold send path
    logic [31:0] now;
    logic [31:0] dt;
    logic [14:0] rh_angle;
    logic [14:0] rounded;
    logic [5:0]  cmd;
    logic [3:0]  bucket;
    logic        new_bucket;
    logic [1:0]  rep;
    logic [5:0]  rep_angle;
    logic        send_new;
    logic        send_rep;
    logic [15:0] dwell_limit;

    assign now = i_calc.item.now_ms;

    // restart puts the state back to its reset values before this item is handled
    always_comb begin
        c_phase       = r_phase;
        c_hold_start  = r_hold_start;
        c_dwell_start = r_dwell_start;
        c_last_time   = r_last_time;
        c_last_angle  = r_last_angle;
        c_bucket      = r_bucket;
        c_rep         = r_rep;
        c_rep_angle   = r_rep_angle;
        if (i_calc.item.restart) begin
            c_phase       = S_RAMP;
            c_hold_start  = 32'd0;
            c_dwell_start = 32'd0;
            c_last_time   = 32'd0;
            c_last_angle  = ANGLE_NONE;
            c_bucket      = BUCKET_NONE;
            c_rep         = 2'd0;
            c_rep_angle   = 6'd0;
        end
    end

    // command, bucket and send decisions for ramp and hold
    assign dt          = now - c_last_time;
    assign rh_angle    = (c_phase == S_RAMP) ? {1'b0, i_calc.ramp_q8} : ANGLE_45_Q8;
    assign rounded     = rh_angle + ROUND_HALF;
    assign cmd         = (rounded[14:8] > {1'b0, CMD_MAX}) ? CMD_MAX : rounded[13:8];
    assign bucket      = bucket_of(cmd);
    assign new_bucket  = (bucket != c_bucket);
    assign rep         = new_bucket ? REPEATS : c_rep;
    assign rep_angle   = new_bucket ? cmd : c_rep_angle;
    assign send_new    = (({1'b0, cmd} != c_last_angle) && (dt >= CHANGE_MS))
                         || (dt >= KEEPALIVE_MS);
    assign send_rep    = !send_new && (rep != 2'd0) && (dt >= REPEAT_MS);
    assign dwell_limit = (i_dwell_ms == 16'd0) ? DWELL_DEFAULT : i_dwell_ms;

    // next state and result
    always_comb begin
        n_phase       = c_phase;
        n_hold_start  = c_hold_start;
        n_dwell_start = c_dwell_start;
        n_last_time   = c_last_time;
        n_last_angle  = c_last_angle;
        n_bucket      = c_bucket;
        n_rep         = c_rep;
        n_rep_angle   = c_rep_angle;
        n_out         = '0;

        unique case (c_phase) inside
            S_RAMP, S_HOLD: begin
                n_out.angle_q8 = rh_angle;
                if ((c_phase == S_HOLD) && ((now - c_hold_start) >= HOLD_MS)) begin
                    // hold over: forced 90 offer, acceptance changes nothing
                    n_phase              = S_DWELL;
                    n_dwell_start        = now;
                    n_out.motors_idle    = 1'b1;
                    n_out.send_valid     = 1'b1;
                    n_out.cmd_angle      = CMD_90;
                end else begin
                    if ((c_phase == S_RAMP) && i_calc.sat) begin
                        n_phase      = S_HOLD;
                        n_hold_start = now;
                    end
                    n_bucket    = bucket;
                    n_rep       = rep;
                    n_rep_angle = rep_angle;
                    if (send_new || send_rep) begin
                        n_out.send_valid = 1'b1;
                        n_out.cmd_angle  = send_new ? {1'b0, cmd} : {1'b0, rep_angle};
                        if (i_calc.item.queue_ready) begin
                            n_last_time  = now;
                            n_last_angle = n_out.cmd_angle;
                            if (rep != 2'd0) begin
                                n_rep = rep - 2'd1;
                            end
                        end
                    end
                end
            end
            S_DWELL: begin
                n_out.angle_q8    = ANGLE_90_Q8;
                n_out.motors_idle = 1'b1;
                if (dt >= DWELL_SEND_MS) begin
                    n_out.send_valid = 1'b1;
                    n_out.cmd_angle  = CMD_90;
                    if (i_calc.item.queue_ready) begin
                        n_last_time  = now;
                        n_last_angle = CMD_90;
                    end
                end
                if ((now - c_dwell_start) >= {16'd0, dwell_limit}) begin
                    n_out.exit_request = 1'b1;
                    n_phase            = S_DONE;
                end
            end
            S_DONE: begin
                n_out.angle_q8    = ANGLE_90_Q8;
                n_out.motors_idle = 1'b1;
            end
        endcase

        n_out.phase = n_phase;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= S_RAMP;
            r_hold_start  <= 32'd0;
            r_dwell_start <= 32'd0;
            r_last_time   <= 32'd0;
            r_last_angle  <= ANGLE_NONE;
            r_bucket      <= BUCKET_NONE;
            r_rep         <= 2'd0;
            r_rep_angle   <= 6'd0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
        end else if (i_en) begin
            r_out_valid <= i_calc_valid;
            if (i_calc_valid) begin
                r_phase       <= n_phase;
                r_hold_start  <= n_hold_start;
                r_dwell_start <= n_dwell_start;
                r_last_time   <= n_last_time;
                r_last_angle  <= n_last_angle;
                r_bucket      <= n_bucket;
                r_rep         <= n_rep;
                r_rep_angle   <= n_rep_angle;
                r_out         <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/morph_angle_ramp_sequencer.sv -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - top level
// One input item per tick in, one result item per tick out, while no result is stalled.
// ----------------------------------------------------------------------------
// Takes one item per clock while no result is stalled and holds back the rest; three
// stages form the ramp angle (elapsed time, rate times elapsed on a 32 x 16
// multiplier, divide by 1000 through a reciprocal multiplier with saturation),
// and the fourth updates the phase, send timers and bucket repeats and holds
// the result. The phase state closes its loop within that fourth stage, so items
// follow each other with no gap. The whole pipeline halts while a result is
// stalled; the input stall is the output stall gated by a waiting result.
// Configuration writes are taken in the cycle they are offered (ready is
// always high) and must only be made while no item is in flight.
module morph_angle_ramp_sequencer
    import mars_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_ramp_rate;
    logic [15:0] r_dwell_ms;
    logic [15:0] rate_eff;
    logic        en;
    logic        calc_valid;
    t_calc       calc;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_rate <= RATE_DEFAULT;
            r_dwell_ms  <= DWELL_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RAMP_RATE: r_ramp_rate <= i_cfg_data;
                CFG_DWELL_MS:  r_dwell_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero rate means the default rate
    assign rate_eff = (r_ramp_rate == 16'd0) ? RATE_DEFAULT : r_ramp_rate;

    // pipeline advances unless a finished result is held back
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    mars_ramp_calc u_ramp_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_rate_q8    (rate_eff),
        .o_calc_valid (calc_valid),
        .o_calc       (calc)
    );

    mars_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_calc_valid (calc_valid),
        .i_calc       (calc),
        .i_dwell_ms   (r_dwell_ms),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item)
    );

endmodule

// ----- rtl/mars_checker.sv -----
// ----------------------------------------------------------------------------
// Morph angle ramp sequencer - port checker
// Checks handshake and result consistency seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "morph_angle_ramp_sequencer_macros.svh"

module mars_checker
    import mars_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic out_held;
    logic out_quiet;
    logic exit_seen;
    logic late_phase;

    // terms shared by the checks below
    assign out_held   = o_out_valid && i_out_stall;
    assign out_quiet  = o_out_valid && !o_out_item.send_valid;
    assign exit_seen  = o_out_valid && o_out_item.exit_request;
    assign late_phase = o_out_valid && ((o_out_item.phase == PHASE_DWELL)
                                        || (o_out_item.phase == PHASE_DONE));

    // a stalled result holds
    `MARS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item))

    // input stalls exactly when a result waits under stall
    `MARS_ASSERT_IMPLIES(a_in_stall, i_clk, i_rst_n, 1'b1, o_in_stall == out_held)

    // no offer means a zero command value
    `MARS_ASSERT_IMPLIES(a_idle_value, i_clk, i_rst_n, out_quiet, o_out_item.cmd_angle == 7'd0)

    // exit only on entry to done; dwell and done keep the motors idle
    `MARS_ASSERT_IMPLIES(a_exit_done, i_clk, i_rst_n, exit_seen, o_out_item.phase == PHASE_DONE)
    `MARS_ASSERT_IMPLIES(a_late_idle, i_clk, i_rst_n, late_phase, o_out_item.motors_idle)

endmodule

bind morph_angle_ramp_sequencer mars_checker u_mars_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
